// ----- rtl/nfbta_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nfbta_pkg: shared types and constants
// Request and result structures and the sizing of the tag store.
// ---------------------------------------------------------------------------
package nfbta_pkg;
	localparam int HeapBytes = 65536;
	localparam int TagWords = HeapBytes / 4;
	localparam int AW = $clog2(TagWords);
	// Growth amounts can reach twice the heap size, so byte quantities carry two spare bits.
	localparam int BW = $clog2(HeapBytes) + 2;
	localparam int TW = 17;

	localparam logic [1:0] CMD_INIT = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_FREE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [15:0] request_bytes;
		logic [15:0] block_address;
	} req_t;

	typedef struct packed {
		logic [15:0] address;
		logic [1:0] status;
	} rsp_t;
endpackage

// ----- rtl/next_fit_boundary_tag_allocator.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// next_fit_boundary_tag_allocator
// Next-fit boundary-tag heap allocator over a single-port tag memory.
// ---------------------------------------------------------------------------
// Init writes the first tags and grows the heap by one chunk, failing when it does not fit.
// A free checks the header and footer, then marks the block free and merges it, or refuses.
// An allocate walks block tags from the cursor, wraps once, then carves, growing the heap
// when nothing fits. Zero-size requests and allocates before init are answered from idle.
// Requests: one at a time; the next is accepted once the result has been taken.
// Reset clears break and control, sets the cursor to 8 and the chunk register to 4096; the tag memory is not cleared.
module next_fit_boundary_tag_allocator (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input nfbta_pkg::req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output nfbta_pkg::rsp_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [16:0] cfg_data
);
	localparam int BW = nfbta_pkg::BW;
	localparam int AW = nfbta_pkg::AW;
	localparam int TW = nfbta_pkg::TW;
	localparam logic [BW-1:0] HEAP = BW'(nfbta_pkg::HeapBytes);

	// Micro-op sequencer states.
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DONE = 5'd1;
	localparam logic [4:0] S_WR = 5'd2;
	localparam logic [4:0] S_GROW = 5'd3;
	localparam logic [4:0] S_MRG0 = 5'd4;
	localparam logic [4:0] S_MRG1 = 5'd5;
	localparam logic [4:0] S_MRG2 = 5'd6;
	localparam logic [4:0] S_MRG3 = 5'd7;
	localparam logic [4:0] S_MEND = 5'd8;
	localparam logic [4:0] S_SEEK = 5'd9;
	localparam logic [4:0] S_SEEKW = 5'd10;
	localparam logic [4:0] S_CARV0 = 5'd11;
	localparam logic [4:0] S_CARV1 = 5'd12;
	localparam logic [4:0] S_FRE0 = 5'd13;
	localparam logic [4:0] S_FRE1 = 5'd14;
	localparam logic [4:0] S_FRE2 = 5'd15;
	localparam logic [4:0] S_FRE3 = 5'd16;

	// After-merge destinations.
	localparam logic [1:0] M_INIT = 2'd0;
	localparam logic [1:0] M_ALLOC = 2'd1;
	localparam logic [1:0] M_FREE = 2'd2;

	logic [TW-1:0] mem [nfbta_pkg::TagWords];
	logic [TW-1:0] rdata_q;
	logic rd_oob_q;

	logic [4:0] state_q, ret_q;
	logic [BW-1:0] brk_q, cur_q, bp_q, size_q, psz_q, asize_q, grow_q, ptr_q;
	logic [TW-1:0] ftag_q;
	logic [BW-1:0] wa_q [4];
	logic [TW-1:0] wd_q [4];
	logic [1:0] wi_q, wlast_q, dst_q, st_q;
	logic pass_q, pa_q;
	logic [16:0] chunk_q;
	logic [15:0] res_q;

	// Memory access for this cycle.
	logic rd_en, wr_en;
	logic [BW-1:0] rd_a, wr_a;
	logic [TW-1:0] wr_d, rd_v;

	logic [BW-1:0] chunk_r, chunk_now, tsz, gsz, msz, mbp, rem, baddr;
	logic seek_more, split;

	// Reads past the break see size 0, allocated.
	assign rd_v = rd_oob_q ? TW'(1) : rdata_q;
	assign tsz = BW'({rd_v[TW-1:3], 3'b000});

	assign chunk_r = (BW'(chunk_q) + BW'(7)) & ~BW'(7);
	assign chunk_now = (chunk_r == '0) ? BW'(8) : chunk_r;
	assign gsz = (asize_q > chunk_now) ? asize_q : chunk_now;
	assign msz = size_q + (rd_v[0] ? BW'(0) : tsz) + (pa_q ? BW'(0) : psz_q);
	assign mbp = pa_q ? bp_q : bp_q - psz_q;
	assign rem = tsz - asize_q;
	assign split = (tsz >= asize_q) && (rem >= BW'(16));
	assign seek_more = (ptr_q < brk_q) && (!pass_q || ptr_q < cur_q);
	assign baddr = BW'(in_data.block_address);

	always_ff @(posedge clk) begin
		if (wr_en && wr_a < brk_q) begin
			mem[wr_a[AW+1:2]] <= wr_d;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_a[AW+1:2]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_oob_q <= 1'b0;
		end else if (rd_en) begin
			rd_oob_q <= (rd_a >= brk_q);
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == S_DONE);
	assign out_data.address = res_q;
	assign out_data.status = st_q;

	// Pending write-list driver.
	assign wr_en = (state_q == S_WR);
	assign wr_a = wa_q[wi_q];
	assign wr_d = wd_q[wi_q];

	always_comb begin
		rd_en = 1'b0;
		rd_a = '0;
		case (state_q)
			S_MRG0: begin rd_en = 1'b1; rd_a = bp_q - BW'(4); end
			S_MRG1: begin rd_en = 1'b1; rd_a = bp_q - BW'(8); end
			S_MRG2: begin rd_en = 1'b1; rd_a = bp_q + size_q - BW'(4); end
			S_SEEK: begin rd_en = seek_more; rd_a = ptr_q - BW'(4); end
			S_CARV0: begin rd_en = 1'b1; rd_a = bp_q - BW'(4); end
			S_FRE0: begin rd_en = 1'b1; rd_a = bp_q - BW'(4); end
			S_FRE2: begin rd_en = 1'b1; rd_a = bp_q + size_q - BW'(8); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			brk_q <= '0;
			cur_q <= BW'(8);
			bp_q <= '0;
			size_q <= '0;
			psz_q <= '0;
			asize_q <= '0;
			grow_q <= '0;
			ptr_q <= '0;
			ftag_q <= '0;
			for (int i = 0; i < 4; i++) begin
				wa_q[i] <= '0;
				wd_q[i] <= '0;
			end
			wi_q <= '0;
			wlast_q <= '0;
			dst_q <= M_INIT;
			st_q <= nfbta_pkg::ST_OK;
			pass_q <= 1'b0;
			pa_q <= 1'b0;
			chunk_q <= 17'd4096;
			res_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				chunk_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						st_q <= nfbta_pkg::ST_OK;
						res_q <= '0;
						asize_q <= (BW'(in_data.request_bytes) + BW'(15)) & ~BW'(7);
						bp_q <= baddr;
						case (in_data.command)
							nfbta_pkg::CMD_INIT: begin
								brk_q <= BW'(16);
								cur_q <= BW'(8);
								wa_q[0] <= BW'(0); wd_q[0] <= TW'(0);
								wa_q[1] <= BW'(4); wd_q[1] <= TW'(9);
								wa_q[2] <= BW'(8); wd_q[2] <= TW'(9);
								wa_q[3] <= BW'(12); wd_q[3] <= TW'(1);
								wi_q <= '0;
								wlast_q <= 2'd3;
								ret_q <= S_GROW;
								dst_q <= M_INIT;
								grow_q <= chunk_now;
								state_q <= S_WR;
							end
							nfbta_pkg::CMD_ALLOC: begin
								if (brk_q < BW'(16)) begin
									st_q <= nfbta_pkg::ST_FULL;
									state_q <= S_DONE;
								end else if (in_data.request_bytes == '0) begin
									st_q <= nfbta_pkg::ST_ZERO;
									state_q <= S_DONE;
								end else begin
									ptr_q <= cur_q;
									pass_q <= 1'b0;
									dst_q <= M_ALLOC;
									state_q <= S_SEEK;
								end
							end
							nfbta_pkg::CMD_FREE: begin
								if (brk_q >= BW'(16) && in_data.block_address[2:0] == 3'd0
									&& in_data.block_address >= 16'd16
									&& baddr < brk_q) begin
									state_q <= S_FRE0;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_WR: begin
					if (wi_q == wlast_q) begin
						wi_q <= '0;
						state_q <= ret_q;
					end else begin
						wi_q <= wi_q + 2'd1;
					end
				end
				S_GROW: begin
					if (grow_q > HEAP - brk_q) begin
						st_q <= nfbta_pkg::ST_FULL;
						state_q <= S_DONE;
					end else begin
						bp_q <= brk_q;
						brk_q <= brk_q + grow_q;
						wa_q[0] <= brk_q - BW'(4); wd_q[0] <= TW'(grow_q);
						wa_q[1] <= brk_q + grow_q - BW'(8); wd_q[1] <= TW'(grow_q);
						wa_q[2] <= brk_q + grow_q - BW'(4); wd_q[2] <= TW'(1);
						wi_q <= '0;
						wlast_q <= 2'd2;
						ret_q <= S_MRG0;
						state_q <= S_WR;
					end
				end
				S_MRG0: state_q <= S_MRG1;
				S_MRG1: begin
					size_q <= tsz;
					state_q <= S_MRG2;
				end
				S_MRG2: begin
					// A free previous block with a broken size counts as allocated.
					psz_q <= tsz;
					pa_q <= rd_v[0] || (tsz == '0) || (tsz > bp_q - BW'(8));
					state_q <= S_MRG3;
				end
				S_MRG3: begin
					if (pa_q && rd_v[0]) begin
						state_q <= S_MEND;
					end else begin
						bp_q <= mbp;
						wa_q[0] <= mbp - BW'(4); wd_q[0] <= TW'(msz);
						wa_q[1] <= mbp + msz - BW'(8); wd_q[1] <= TW'(msz);
						wi_q <= '0;
						wlast_q <= 2'd1;
						ret_q <= S_MEND;
						state_q <= S_WR;
					end
				end
				S_MEND: begin
					case (dst_q)
						M_FREE: begin
							cur_q <= bp_q;
							res_q <= bp_q[15:0];
							state_q <= S_DONE;
						end
						M_ALLOC: begin
							cur_q <= bp_q;
							state_q <= S_CARV0;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_SEEK: begin
					if (seek_more) begin
						state_q <= S_SEEKW;
					end else if (!pass_q) begin
						pass_q <= 1'b1;
						ptr_q <= BW'(8);
					end else begin
						grow_q <= gsz;
						state_q <= S_GROW;
					end
				end
				S_SEEKW: begin
					if (tsz == '0) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							ptr_q <= BW'(8);
							state_q <= S_SEEK;
						end else begin
							grow_q <= gsz;
							state_q <= S_GROW;
						end
					end else if (!rd_v[0] && asize_q <= tsz) begin
						cur_q <= ptr_q;
						bp_q <= ptr_q;
						state_q <= S_CARV0;
					end else begin
						ptr_q <= ptr_q + tsz;
						state_q <= S_SEEK;
					end
				end
				S_CARV0: state_q <= S_CARV1;
				S_CARV1: begin
					if (split) begin
						wa_q[0] <= bp_q - BW'(4); wd_q[0] <= TW'(asize_q | BW'(1));
						wa_q[1] <= bp_q + asize_q - BW'(8); wd_q[1] <= TW'(asize_q | BW'(1));
						wa_q[2] <= bp_q + asize_q - BW'(4); wd_q[2] <= TW'(rem);
						wa_q[3] <= bp_q + tsz - BW'(8); wd_q[3] <= TW'(rem);
						wlast_q <= 2'd3;
					end else begin
						wa_q[0] <= bp_q - BW'(4); wd_q[0] <= TW'(tsz | BW'(1));
						wa_q[1] <= bp_q + tsz - BW'(8); wd_q[1] <= TW'(tsz | BW'(1));
						wlast_q <= 2'd1;
					end
					wi_q <= '0;
					res_q <= bp_q[15:0];
					ret_q <= S_DONE;
					state_q <= S_WR;
				end
				S_FRE0: state_q <= S_FRE1;
				S_FRE1: begin
					// Header arrived; it must be allocated and fit below the break.
					if (!rd_v[0] || tsz == '0 || tsz > brk_q - bp_q) begin
						state_q <= S_DONE;
					end else begin
						size_q <= tsz;
						ftag_q <= rd_v;
						state_q <= S_FRE2;
					end
				end
				S_FRE2: state_q <= S_FRE3;
				S_FRE3: begin
					if (rd_v != ftag_q) begin
						state_q <= S_DONE;
					end else begin
						wa_q[0] <= bp_q - BW'(4); wd_q[0] <= TW'(size_q);
						wa_q[1] <= bp_q + size_q - BW'(8); wd_q[1] <= TW'(size_q);
						wi_q <= '0;
						wlast_q <= 2'd1;
						ret_q <= S_MRG0;
						dst_q <= M_FREE;
						state_q <= S_WR;
					end
				end
				S_DONE: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("result shown while idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("result dropped or changed");
	a_brk: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q <= HEAP) else $error("break past heap end");
	a_cur: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q[2:0] == 3'd0) else $error("cursor misaligned");
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wi_q <= wlast_q)) else $error("write list overrun");
`endif
endmodule
